### rtl/hbe_pkg.sv
// Shared types, constants and helpers of the HTTP body extractor.
package hbe_pkg;

    // Width of the length, chunk size and body counters
    localparam int COUNT_BITS = 32;
    localparam int MATCH_BITS = 5;
    localparam int TDATA_BITS = 48;

    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [MATCH_BITS-1:0] match_t;

    // Header patterns, compared against lower-cased input
    localparam int LEN_PAT_N = 16;
    localparam int CHK_PAT_N = 26;
    localparam logic [8*LEN_PAT_N-1:0] LEN_PAT = "content-length: ";
    localparam logic [8*CHK_PAT_N-1:0] CHK_PAT = "transfer-encoding: chunked";

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // End-of-message status codes
    localparam logic [1:0] ST_BODY          = 2'd0;
    localparam logic [1:0] ST_NO_HEADER_END = 2'd1;
    localparam logic [1:0] ST_EMPTY_BODY    = 2'd2;

    typedef enum logic [2:0] {
        PH_HEAD   = 3'd0,
        PH_LENGTH = 3'd1,
        PH_SIZE   = 3'd2,
        PH_DATA   = 3'd3,
        PH_SKIP   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        NP_IDLE   = 2'd0,
        NP_LEAD   = 2'd1,
        NP_DIGITS = 2'd2,
        NP_DONE   = 2'd3
    } np_t;

    // One accepted input item
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        msg_end;
        logic [1:0]  status;
        logic [31:0] body_length;
    } result_t;

    // Clamp a counter value to the 32-bit length field
    function automatic logic [31:0] sat32(cnt_t v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

endpackage

### rtl/hbe_in_stage.sv
// Input register of the HTTP body extractor.
module hbe_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hbe_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output hbe_pkg::in_item_t item
);
    import hbe_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Take a new item when empty or when the held one moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

### rtl/hbe_parser.sv
// Per-byte header matcher, number parser and body framing state.
module hbe_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  hbe_pkg::in_item_t item,
    output hbe_pkg::result_t  result
);
    import hbe_pkg::*;

    localparam int WIDE_BITS = COUNT_BITS + 5;
    localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        np_t  np;
        cnt_t value;
    } num_t;

    phase_t phase_reg, phase_next;
    logic [1:0] end_match_reg, end_match_next;
    match_t length_match_reg, length_match_next;
    match_t chunk_match_reg, chunk_match_next;
    logic length_found_reg, length_found_next;
    logic chunked_found_reg, chunked_found_next;
    np_t number_parse_reg, number_parse_next;
    cnt_t number_value_reg, number_value_next;
    cnt_t bytes_left_reg, bytes_left_next;
    cnt_t body_count_reg, body_count_next;
    logic cr_seen_reg, cr_seen_next;

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? 8'(c + 8'd32) : c;
    endfunction

    function automatic logic [7:0] len_char(match_t k);
        logic [7:0] ch;
        ch = 8'h00;
        for (int i = 0; i < LEN_PAT_N; i++) begin
            if (k == match_t'(i)) ch = LEN_PAT[8*(LEN_PAT_N-1-i) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] chk_char(match_t k);
        logic [7:0] ch;
        ch = 8'h00;
        for (int i = 0; i < CHK_PAT_N; i++) begin
            if (k == match_t'(i)) ch = CHK_PAT[8*(CHK_PAT_N-1-i) +: 8];
        end
        return ch;
    endfunction

    // Advance a pattern match, restarting on the first pattern character
    function automatic match_t pat_step(match_t k, match_t n, logic [7:0] pat_k,
                                        logic [7:0] pat_0, logic [7:0] c);
        logic [7:0] lc;
        lc = to_lower(c);
        if (k < n && lc == pat_k) return match_t'(k + match_t'(1));
        return (lc == pat_0) ? match_t'(1) : match_t'(0);
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF;
    endfunction

    // Saturating v * base + d, base 10 or 16
    function automatic cnt_t accumulate(cnt_t v, logic hex, logic [3:0] d);
        logic [WIDE_BITS-1:0] w;
        logic [WIDE_BITS-1:0] prod;
        w = WIDE_BITS'(v);
        prod = hex ? (w << 4) : ((w << 3) + (w << 1));
        prod = prod + WIDE_BITS'(d);
        return (prod > WIDE_BITS'(CNT_MAX)) ? CNT_MAX : prod[COUNT_BITS-1:0];
    endfunction

    // One byte of a decimal length or hex chunk size
    function automatic num_t feed_number(np_t np, cnt_t v, logic [7:0] c, logic hex);
        logic       d_ok;
        logic [3:0] d;
        num_t       r;
        d_ok = 1'b0;
        d    = 4'd0;
        r.np    = np;
        r.value = v;
        if (c >= "0" && c <= "9") begin
            d_ok = 1'b1;
            d    = 4'(c - "0");
        end else if (hex && c >= "a" && c <= "f") begin
            d_ok = 1'b1;
            d    = 4'(c - "a" + 8'd10);
        end else if (hex && c >= "A" && c <= "F") begin
            d_ok = 1'b1;
            d    = 4'(c - "A" + 8'd10);
        end
        case (np)
            NP_LEAD: begin
                if (is_blank(c) || (hex && c == CH_CR)) begin
                    r.np = NP_LEAD;
                end else if (!hex && c == CH_PLUS) begin
                    r.np = NP_DIGITS;
                end else if (d_ok) begin
                    r.value = COUNT_BITS'(d);
                    r.np    = NP_DIGITS;
                end else begin
                    r.value = '0;
                    r.np    = NP_DONE;
                end
            end
            NP_DIGITS: begin
                if (d_ok) r.value = accumulate(v, hex, d);
                else      r.np    = NP_DONE;
            end
            default: begin
                r.np = np;
            end
        endcase
        return r;
    endfunction

    // Next state for the byte in the input register
    always_comb begin
        logic [7:0] c;
        logic [7:0] c_eff;
        logic       line_end;
        num_t       fed;
        c        = item.data;
        c_eff    = c;
        line_end = cr_seen_reg && (c == CH_LF);
        fed      = '{np: number_parse_reg, value: number_value_reg};

        phase_next         = phase_reg;
        end_match_next     = end_match_reg;
        length_match_next  = length_match_reg;
        chunk_match_next   = chunk_match_reg;
        length_found_next  = length_found_reg;
        chunked_found_next = chunked_found_reg;
        number_parse_next  = number_parse_reg;
        number_value_next  = number_value_reg;
        bytes_left_next    = bytes_left_reg;
        body_count_next    = body_count_reg;

        case (phase_reg)
            PH_HEAD: begin
                if (length_found_reg) begin
                    fed = feed_number(number_parse_reg, number_value_reg, c, 1'b0);
                    number_parse_next = fed.np;
                    number_value_next = fed.value;
                end
                if (!length_found_reg) begin
                    length_match_next = pat_step(length_match_reg, match_t'(LEN_PAT_N),
                                                 len_char(length_match_reg),
                                                 len_char(match_t'(0)), c);
                    if (length_match_next == match_t'(LEN_PAT_N)) begin
                        length_found_next = 1'b1;
                        number_parse_next = NP_LEAD;
                        number_value_next = '0;
                    end
                end
                if (!chunked_found_reg) begin
                    chunk_match_next = pat_step(chunk_match_reg, match_t'(CHK_PAT_N),
                                                chk_char(chunk_match_reg),
                                                chk_char(match_t'(0)), c);
                    if (chunk_match_next == match_t'(CHK_PAT_N)) begin
                        chunked_found_next = 1'b1;
                    end
                end
                // Track CR LF CR LF and pick the framing at the blank line
                if (end_match_reg == 2'd3 && c == CH_LF) begin
                    end_match_next = 2'd0;
                    if (length_found_next) begin
                        bytes_left_next = number_value_next;
                        phase_next = (number_value_next == '0) ? PH_DONE : PH_LENGTH;
                    end else if (chunked_found_next) begin
                        number_parse_next = NP_LEAD;
                        number_value_next = '0;
                        phase_next        = PH_SIZE;
                    end else begin
                        phase_next = PH_DONE;
                    end
                    c_eff = 8'h00;
                end else if ((end_match_reg == 2'd0 || end_match_reg == 2'd2) &&
                             c == CH_CR) begin
                    end_match_next = 2'(end_match_reg + 2'd1);
                end else if (end_match_reg == 2'd1 && c == CH_LF) begin
                    end_match_next = 2'd2;
                end else begin
                    end_match_next = (c == CH_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_LENGTH: begin
                if (body_count_reg != CNT_MAX) body_count_next = body_count_reg + 1'b1;
                if (bytes_left_reg != '0) bytes_left_next = bytes_left_reg - 1'b1;
                if (bytes_left_next == '0) phase_next = PH_DONE;
            end
            PH_SIZE: begin
                fed = feed_number(number_parse_reg, number_value_reg, c, 1'b1);
                number_parse_next = fed.np;
                number_value_next = fed.value;
                if (line_end) begin
                    if (fed.value == '0) begin
                        phase_next = PH_DONE;
                    end else begin
                        bytes_left_next = fed.value;
                        phase_next      = PH_DATA;
                    end
                    number_parse_next = NP_IDLE;
                end
            end
            PH_DATA: begin
                if (body_count_reg != CNT_MAX) body_count_next = body_count_reg + 1'b1;
                if (bytes_left_reg != '0) bytes_left_next = bytes_left_reg - 1'b1;
                if (bytes_left_next == '0) phase_next = PH_SKIP;
                c_eff = 8'h00;
            end
            PH_SKIP: begin
                if (line_end) begin
                    number_parse_next = NP_LEAD;
                    number_value_next = '0;
                    phase_next        = PH_SIZE;
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
        cr_seen_next = (c_eff == CH_CR) && !line_end;
    end

    // Result for the byte in the input register
    always_comb begin
        result.body_valid  = (phase_reg == PH_LENGTH) || (phase_reg == PH_DATA);
        result.body_byte   = result.body_valid ? item.data : 8'h00;
        result.msg_end     = item.last;
        result.body_length = sat32(body_count_next);
        result.status      = ST_BODY;
        if (item.last) begin
            if (phase_next == PH_HEAD)       result.status = ST_NO_HEADER_END;
            else if (body_count_next == '0) result.status = ST_EMPTY_BODY;
        end
    end

    // Hold state; return to reset after the final byte of a response
    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && item.last)) begin
            phase_reg         <= PH_HEAD;
            end_match_reg     <= 2'd0;
            length_match_reg  <= '0;
            chunk_match_reg   <= '0;
            length_found_reg  <= 1'b0;
            chunked_found_reg <= 1'b0;
            number_parse_reg  <= NP_IDLE;
            number_value_reg  <= '0;
            bytes_left_reg    <= '0;
            body_count_reg    <= '0;
            cr_seen_reg       <= 1'b0;
        end else if (fire) begin
            phase_reg         <= phase_next;
            end_match_reg     <= end_match_next;
            length_match_reg  <= length_match_next;
            chunk_match_reg   <= chunk_match_next;
            length_found_reg  <= length_found_next;
            chunked_found_reg <= chunked_found_next;
            number_parse_reg  <= number_parse_next;
            number_value_reg  <= number_value_next;
            bytes_left_reg    <= bytes_left_next;
            body_count_reg    <= body_count_next;
            cr_seen_reg       <= cr_seen_next;
        end
    end

endmodule

### rtl/hbe_out_stage.sv
// Result register of the HTTP body extractor.
module hbe_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  hbe_pkg::result_t result,
    output logic             advance,
    output logic             m_valid,
    input  logic             m_ready,
    output hbe_pkg::result_t m_result
);
    import hbe_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // Move a result in when the register is empty or being drained
    assign advance  = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_valid) begin
            result_reg <= result;
        end
    end

endmodule

### rtl/http_body_extractor.sv
// Top level of the HTTP body extractor.
//
// Feed the raw response on the slave stream, one byte per item, with tlast on
// its final byte. Every input item yields exactly one result item on the
// master stream: tuser flags whether tdata carries a body byte, tlast repeats
// the input tlast, and on that last result the status field reports body
// found, no header end, or empty body. body_length counts body bytes so far.
// Header end, Content-Length and chunked framing are all found on the fly.
//
// Throughput is one item per cycle while m_axis_tready stays high: each
// byte's header match, number parse and framing update is a single state
// step between the input register and the result register, so every item
// passes through those two registers in turn. When the receiver stalls, the
// result register holds; an empty input register takes one more item, and
// once it is full s_axis_tready follows m_axis_tready low in the same cycle.
// Reset empties both registers and clears the framing state; no memory
// needs a clearing pass. After the tlast item the framing state returns to
// reset, so the next byte starts a new response.
module http_body_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] body_byte, [9:8] status,
                                        // [41:10] body_length, [47:42] zero
    output logic        m_axis_tuser,   // body_valid
    output logic        m_axis_tlast    // msg_end
);
    import hbe_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    result_t  result;
    result_t  m_result;

    assign s_item.data = s_axis_tdata;
    assign s_item.last = s_axis_tlast;

    hbe_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    hbe_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (item_valid && advance),
        .item    (item),
        .result  (result)
    );

    hbe_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_result   (m_result)
    );

    // Pack the result fields onto the master stream
    assign m_axis_tdata = {6'b0, m_result.body_length, m_result.status, m_result.body_byte};
    assign m_axis_tuser = m_result.body_valid;
    assign m_axis_tlast = m_result.msg_end;

endmodule

### rtl/hbe_checker.sv
// Port-level assertions for the HTTP body extractor, bound to the top level.
module hbe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    import hbe_pkg::*;

    // No result is shown in the cycle after reset
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A non-body result carries a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
        else $error("byte set without body flag");

    // Status is reported only on the final result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[9:8] == ST_BODY)
        else $error("status set before message end");

    // A body byte on the final result means the body was found
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast && m_axis_tuser |-> m_axis_tdata[9:8] == ST_BODY
            && m_axis_tdata[41:10] != 32'd0)
        else $error("body byte with failure status");

endmodule

bind http_body_extractor hbe_checker u_hbe_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
